### hw/rtl/fixed_point_atan2_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fixed-point atan2 unit
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_ATAN2_UNIT_MACROS_SVH
`define FIXED_POINT_ATAN2_UNIT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define AT2_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define AT2_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/at2_pkg.sv
// ----------------------------------------------------------------------------
// Package for the fixed-point atan2 unit
// Widths, angle constants, pipeline lane types and the arctangent table.
// ----------------------------------------------------------------------------
package at2_pkg;

  localparam int unsigned MagW = 32;
  localparam int unsigned QuoW = 7;
  localparam int unsigned AngW = 15;
  localparam int unsigned AccW = 16;
  localparam int unsigned RomW = 12;

  localparam logic signed [AngW-1:0] ANG_ZERO        = 15'sd0;
  localparam logic signed [AngW-1:0] ANG_QUARTER_PI  = 15'sd3217;
  localparam logic signed [AngW-1:0] ANG_HALF_PI     = 15'sd6434;
  localparam logic signed [AngW-1:0] ANG_3QUARTER_PI = 15'sd9651;
  localparam logic signed [AngW-1:0] ANG_PI          = 15'sd12868;

  // How the final angle is formed from the octant base.
  typedef struct packed {
    logic                   special;  // axis, origin or diagonal: base is the answer
    logic                   add;      // add the table entry, else subtract it
    logic signed [AngW-1:0] base;
  } at2_tag_t;

  // One item as it travels down the divider chain.
  typedef struct packed {
    logic            vld;
    logic [MagW-1:0] rem;
    logic [MagW-1:0] den;   // the larger magnitude, used as the divisor
    logic [QuoW-1:0] quo;
    at2_tag_t        tag;
  } at2_lane_t;

  // Entry i is atan(i/128) with 12 fraction bits.
  localparam logic [RomW-1:0] ATAN_ROM [129] = '{
    12'h000, 12'h020, 12'h040, 12'h060, 12'h080, 12'h0a0, 12'h0c0, 12'h0e0,
    12'h100, 12'h120, 12'h13f, 12'h15f, 12'h17f, 12'h19f, 12'h1be, 12'h1de,
    12'h1fd, 12'h21d, 12'h23c, 12'h25c, 12'h27b, 12'h29a, 12'h2b9, 12'h2d8,
    12'h2f7, 12'h316, 12'h335, 12'h354, 12'h372, 12'h391, 12'h3af, 12'h3cd,
    12'h3eb, 12'h409, 12'h427, 12'h445, 12'h463, 12'h481, 12'h49e, 12'h4bb,
    12'h4d9, 12'h4f6, 12'h513, 12'h52f, 12'h54c, 12'h569, 12'h585, 12'h5a1,
    12'h5be, 12'h5da, 12'h5f5, 12'h611, 12'h62d, 12'h648, 12'h663, 12'h67e,
    12'h699, 12'h6b4, 12'h6cf, 12'h6e9, 12'h703, 12'h71e, 12'h738, 12'h751,
    12'h76b, 12'h785, 12'h79e, 12'h7b7, 12'h7d0, 12'h7e9, 12'h802, 12'h81a,
    12'h833, 12'h84b, 12'h863, 12'h87b, 12'h893, 12'h8aa, 12'h8c2, 12'h8d9,
    12'h8f0, 12'h907, 12'h91e, 12'h934, 12'h94b, 12'h961, 12'h977, 12'h98d,
    12'h9a3, 12'h9b9, 12'h9ce, 12'h9e3, 12'h9f9, 12'ha0e, 12'ha23, 12'ha37,
    12'ha4c, 12'ha60, 12'ha74, 12'ha89, 12'ha9c, 12'hab0, 12'hac4, 12'had7,
    12'haeb, 12'hafe, 12'hb11, 12'hb24, 12'hb37, 12'hb49, 12'hb5c, 12'hb6e,
    12'hb80, 12'hb92, 12'hba4, 12'hbb6, 12'hbc8, 12'hbd9, 12'hbeb, 12'hbfc,
    12'hc0d, 12'hc1e, 12'hc2f, 12'hc3f, 12'hc50, 12'hc60, 12'hc71, 12'hc81,
    12'hc91
  };

  function automatic logic [RomW-1:0] atan_lookup(input logic [QuoW-1:0] idx);
    logic [QuoW:0] addr;
    addr = {1'b0, idx};
    return ATAN_ROM[addr];
  endfunction

endpackage

### hw/rtl/at2_prep.sv
// ----------------------------------------------------------------------------
// Octant reduction stage
// Takes signed coordinates, classifies the vector and registers the divider operands.
// ----------------------------------------------------------------------------
module at2_prep (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         vld,
  input  logic signed [at2_pkg::MagW-1:0] y_coord,
  input  logic signed [at2_pkg::MagW-1:0] x_coord,
  output at2_pkg::at2_lane_t           lane
);
  import at2_pkg::*;

  logic [MagW-1:0] yu, xu, ym, xm;
  logic            yneg, xneg, x_big;
  at2_lane_t       lane_next;

  always_comb begin
    yu    = y_coord;
    xu    = x_coord;
    yneg  = yu[MagW-1];
    xneg  = xu[MagW-1];
    // Unsigned magnitudes, so the most negative input maps to 2^31 cleanly.
    ym    = yneg ? (MagW'(0) - yu) : yu;
    xm    = xneg ? (MagW'(0) - xu) : xu;
    x_big = xm > ym;

    lane_next             = '0;
    lane_next.vld         = vld;
    lane_next.quo         = '0;
    lane_next.rem         = x_big ? ym : xm;
    lane_next.den         = x_big ? xm : ym;
    lane_next.tag.special = 1'b0;
    lane_next.tag.add     = 1'b0;
    lane_next.tag.base    = ANG_ZERO;

    if (yu == '0) begin
      lane_next.tag.special = 1'b1;
      lane_next.tag.base    = xneg ? ANG_PI : ANG_ZERO;
    end else if (xu == '0) begin
      lane_next.tag.special = 1'b1;
      lane_next.tag.base    = yneg ? -ANG_HALF_PI : ANG_HALF_PI;
    end else if (xm == ym) begin
      lane_next.tag.special = 1'b1;
      case ({yneg, xneg})
        2'b00:   lane_next.tag.base = ANG_QUARTER_PI;
        2'b01:   lane_next.tag.base = ANG_3QUARTER_PI;
        2'b11:   lane_next.tag.base = -ANG_3QUARTER_PI;
        default: lane_next.tag.base = -ANG_QUARTER_PI;
      endcase
    end else begin
      case ({yneg, xneg})
        2'b00: begin
          lane_next.tag.base = x_big ? ANG_ZERO : ANG_HALF_PI;
          lane_next.tag.add  = x_big;
        end
        2'b01: begin
          lane_next.tag.base = x_big ? ANG_PI : ANG_HALF_PI;
          lane_next.tag.add  = !x_big;
        end
        2'b11: begin
          lane_next.tag.base = x_big ? -ANG_PI : -ANG_HALF_PI;
          lane_next.tag.add  = x_big;
        end
        default: begin
          lane_next.tag.base = x_big ? ANG_ZERO : -ANG_HALF_PI;
          lane_next.tag.add  = !x_big;
        end
      endcase
    end

    // Fixed answers still ride the divider; give it harmless operands.
    if (lane_next.tag.special) begin
      lane_next.rem = '0;
      lane_next.den = MagW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane.vld <= 1'b0;
    end else if (en) begin
      lane.vld <= lane_next.vld;
    end
    if (en) begin
      lane.rem <= lane_next.rem;
      lane.den <= lane_next.den;
      lane.quo <= lane_next.quo;
      lane.tag <= lane_next.tag;
    end
  end

endmodule

### hw/rtl/at2_cell.sv
// ----------------------------------------------------------------------------
// Restoring divider cell
// Produces one quotient bit of floor(small*128/large) and passes the item on.
// ----------------------------------------------------------------------------
`include "fixed_point_atan2_unit_macros.svh"

module at2_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  at2_pkg::at2_lane_t lane_in,
  output at2_pkg::at2_lane_t lane_out
);
  import at2_pkg::*;

  logic [MagW:0]   rem2, diff;
  logic            ge;
  logic            rem_ok, den_ok;
  at2_lane_t       lane_next;

  always_comb begin
    rem2           = {lane_in.rem, 1'b0};
    diff           = rem2 - {1'b0, lane_in.den};
    ge             = rem2 >= {1'b0, lane_in.den};
    lane_next      = lane_in;
    lane_next.rem  = ge ? diff[MagW-1:0] : rem2[MagW-1:0];
    lane_next.quo  = {lane_in.quo[QuoW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_out.vld <= 1'b0;
    end else if (en) begin
      lane_out.vld <= lane_next.vld;
    end
    if (en) begin
      lane_out.rem <= lane_next.rem;
      lane_out.den <= lane_next.den;
      lane_out.quo <= lane_next.quo;
      lane_out.tag <= lane_next.tag;
    end
  end

  assign rem_ok = !lane_out.vld || (lane_out.rem < lane_out.den);
  assign den_ok = !lane_out.vld || (lane_out.den != '0);

  `AT2_ASSERT_ALWAYS(a_rem_below_divisor, rem_ok, "remainder not below divisor")
  `AT2_ASSERT_ALWAYS(a_divisor_nonzero, den_ok, "zero divisor in chain")
  `AT2_ASSERT_NEXT(a_hold_when_stalled, !en, $stable(lane_out), "cell changed while stalled")
  `AT2_ASSERT_NEXT(a_valid_moves, en && lane_in.vld, lane_out.vld, "item lost in cell")

endmodule

### hw/rtl/at2_post.sv
// ----------------------------------------------------------------------------
// Table lookup and output register
// Reads the arctangent table at the quotient and applies the octant base.
// ----------------------------------------------------------------------------
module at2_post (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  at2_pkg::at2_lane_t            lane_in,
  output logic                          rsp_valid,
  output logic signed [at2_pkg::AngW-1:0] angle
);
  import at2_pkg::*;

  logic [AccW-1:0] base_ext, rom_ext, sum;
  logic [AngW-1:0] angle_next;

  always_comb begin
    base_ext   = {lane_in.tag.base[AngW-1], lane_in.tag.base};
    rom_ext    = AccW'(atan_lookup(lane_in.quo));
    sum        = lane_in.tag.add ? (base_ext + rom_ext) : (base_ext - rom_ext);
    angle_next = lane_in.tag.special ? lane_in.tag.base : sum[AngW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= lane_in.vld;
    end
    if (en) begin
      angle <= angle_next;
    end
  end

endmodule

### hw/rtl/fixed_point_atan2_unit.sv
// ----------------------------------------------------------------------------
// Fixed-point atan2 unit
// Four-quadrant arctangent by octant reduction, a bit-per-cell divider chain
// and a 129-entry arctangent table.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (req_valid, req_stall) carries one item per vector:
// y_coord and x_coord, signed with 12 fraction bits. The response channel
// (rsp_valid, rsp_stall) returns one item per request, angle, signed with
// 12 fraction bits, where 12868 stands for pi.
// The pipeline is a reduction stage, seven divider cells that each settle
// one quotient bit with a 33-bit compare and subtract, and a lookup stage
// that drives the output register. An accepted item passes in turn through
// the reduction register, the seven cell registers and the output register,
// and a new item is taken every cycle unless the receiver stalls; the rate
// of one item per cycle is set by the one-bit-per-cell divider chain.
// When the receiver stalls a valid result, the whole pipeline freezes and
// req_stall rises in the same cycle; nothing is dropped or repeated.
// Reset clears every stage's valid bit, so the unit comes up empty and
// ready for the next cycle.
// ----------------------------------------------------------------------------
module fixed_point_atan2_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic signed [at2_pkg::MagW-1:0] y_coord,
  input  logic signed [at2_pkg::MagW-1:0] x_coord,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic signed [at2_pkg::AngW-1:0] angle
);
  import at2_pkg::*;

  // The pipeline advances unless a finished result is being held back.
  logic      en;
  at2_lane_t lane [QuoW+1];

  assign en        = !(rsp_valid && rsp_stall);
  assign req_stall = !en;

  at2_prep u_prep (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld     (req_valid),
    .y_coord (y_coord),
    .x_coord (x_coord),
    .lane    (lane[0])
  );

  // One cell per quotient bit, most significant bit first.
  for (genvar i = 0; i < QuoW; i++) begin : g_cell
    at2_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .lane_in  (lane[i]),
      .lane_out (lane[i+1])
    );
  end

  at2_post u_post (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .lane_in   (lane[QuoW]),
    .rsp_valid (rsp_valid),
    .angle     (angle)
  );

endmodule
